// ===== rtl/core/lcbs_pkg.sv =====
`timescale 1ns / 1ps

package lcbs_pkg;

  // cube geometry
  localparam int X_SIZE = 8;
  localparam int Y_SIZE = 8;
  localparam int Z_SIZE = 8;

  localparam int VOXELS = X_SIZE * Y_SIZE * Z_SIZE;
  localparam int LAYER  = X_SIZE * Y_SIZE;
  localparam int ADDR_W = $clog2(VOXELS);
  localparam int IDX_W  = $clog2(LAYER);

  // item field widths
  localparam int COORD_W  = 3;
  localparam int PLANE_W  = 3;
  localparam int BYTE_W   = 8;
  localparam int COLOUR_W = 3 * BYTE_W;

  typedef enum logic [1:0] {
    OP_OR    = 2'd0,
    OP_FILL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  // load request from the sequencer to the output stage
  typedef struct packed {
    logic               load;
    logic               last;
    logic               zero;
    logic [PLANE_W-1:0] plane;
  } ld_t;

endpackage

// ===== rtl/core/lcbs_voxel_ram.sv =====
`timescale 1ns / 1ps

module lcbs_voxel_ram (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [lcbs_pkg::ADDR_W-1:0]    waddr_i,
  input  logic [lcbs_pkg::COLOUR_W-1:0]  wdata_i,
  input  logic                           re_i,
  input  logic [lcbs_pkg::ADDR_W-1:0]    raddr_i,
  output logic [lcbs_pkg::COLOUR_W-1:0]  rdata_o
);
  import lcbs_pkg::*;

  logic [COLOUR_W-1:0] mem [VOXELS];
  logic [COLOUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lcbs_out_stage.sv =====
`timescale 1ns / 1ps

module lcbs_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcbs_pkg::ld_t                  ld_i,
  input  logic [lcbs_pkg::COLOUR_W-1:0]  rdata_i,
  output logic                           can_load_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           red_bit_o,
  output logic                           green_bit_o,
  output logic                           blue_bit_o,
  output logic                           latch_now_o
);
  import lcbs_pkg::*;

  logic valid_q, valid_d;
  logic red_q, green_q, blue_q, latch_q;
  logic [BYTE_W-1:0] red_byte, green_byte, blue_byte;

  assign red_byte   = rdata_i[2*BYTE_W +: BYTE_W];
  assign green_byte = rdata_i[BYTE_W +: BYTE_W];
  assign blue_byte  = rdata_i[0 +: BYTE_W];

  assign can_load_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (ld_i.load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.load) begin
      red_q   <= !ld_i.zero && red_byte[ld_i.plane];
      green_q <= !ld_i.zero && green_byte[ld_i.plane];
      blue_q  <= !ld_i.zero && blue_byte[ld_i.plane];
      latch_q <= ld_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign red_bit_o   = red_q;
  assign green_bit_o = green_q;
  assign blue_bit_o  = blue_q;
  assign latch_now_o = latch_q;

  // never overwrite a result that is still stalled
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.load |-> (!valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

// ===== rtl/core/lcbs_sequencer.sv =====
`timescale 1ns / 1ps

module lcbs_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lcbs_pkg::op_e                  op_i,
  input  logic [lcbs_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [lcbs_pkg::COORD_W-1:0]   pos_y_i,
  input  logic [lcbs_pkg::COORD_W-1:0]   pos_z_i,
  input  logic [lcbs_pkg::COLOUR_W-1:0]  colour_i,
  input  logic [lcbs_pkg::PLANE_W-1:0]   plane_i,
  output logic                           ram_we_o,
  output logic [lcbs_pkg::ADDR_W-1:0]    ram_waddr_o,
  output logic [lcbs_pkg::COLOUR_W-1:0]  ram_wdata_o,
  output logic                           ram_re_o,
  output logic [lcbs_pkg::ADDR_W-1:0]    ram_raddr_o,
  input  logic [lcbs_pkg::COLOUR_W-1:0]  ram_rdata_i,
  input  logic                           can_load_i,
  output lcbs_pkg::ld_t                  ld_o
);
  import lcbs_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_OR_WR = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;
  logic [COORD_W-1:0]  z_q, z_d;
  logic [PLANE_W-1:0]  plane_q, plane_d;
  logic                zero_q, zero_d;
  logic                iss_done_q, iss_done_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;
  logic                in_range;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   scan_addr;
  logic                sweep_end;
  logic                load;
  logic                issue;

  assign in_range = (int'(pos_x_i) < X_SIZE) && (int'(pos_y_i) < Y_SIZE)
                 && (int'(pos_z_i) < Z_SIZE);
  assign in_addr  = (ADDR_W'(pos_z_i) * ADDR_W'(Y_SIZE) + ADDR_W'(pos_y_i))
                    * ADDR_W'(X_SIZE) + ADDR_W'(pos_x_i);
  assign scan_addr = ADDR_W'(z_q) * ADDR_W'(LAYER) + ADDR_W'(cnt_q[IDX_W-1:0]);
  assign sweep_end = (cnt_q == ADDR_W'(VOXELS - 1));

  assign load  = (state_q == S_SCAN) && pend_q && can_load_i;
  assign issue = (state_q == S_SCAN) && !iss_done_q && (!pend_q || load);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    colour_d    = colour_q;
    z_d         = z_q;
    plane_d     = plane_q;
    zero_d      = zero_q;
    iss_done_d  = iss_done_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_addr;

    unique case (state_q)
      S_INIT, S_FILL, S_CLEAR: begin
        ram_we_o = 1'b1;
        if (state_q == S_FILL) begin
          ram_wdata_o = colour_q;
        end
        if (sweep_end) begin
          cnt_d      = '0;
          iss_done_d = 1'b0;
          state_d    = (state_q == S_CLEAR) ? S_SCAN : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d      = '0;
          iss_done_d = 1'b0;
          unique case (op_i)
            OP_OR: begin
              if (in_range) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = in_addr;
                addr_d      = in_addr;
                colour_d    = colour_i;
                state_d     = S_OR_WR;
              end
            end
            OP_FILL: begin
              colour_d = colour_i;
              state_d  = S_FILL;
            end
            OP_CLEAR: begin
              z_d     = '0;
              plane_d = '0;
              zero_d  = 1'b0;
              state_d = S_CLEAR;
            end
            OP_SCAN: begin
              z_d     = pos_z_i;
              plane_d = plane_i;
              zero_d  = !(int'(pos_z_i) < Z_SIZE);
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_OR_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q;
        ram_wdata_o = ram_rdata_i | colour_q;
        state_d     = S_IDLE;
      end
      S_SCAN: begin
        if (load) begin
          pend_d = 1'b0;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end
        end
        if (issue) begin
          ram_re_o    = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (cnt_q[IDX_W-1:0] == IDX_W'(LAYER - 1));
          if (cnt_q[IDX_W-1:0] == IDX_W'(LAYER - 1)) begin
            iss_done_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      iss_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_done_q  <= iss_done_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    colour_q <= colour_d;
    z_q      <= z_d;
    plane_q  <= plane_d;
    zero_q   <= zero_d;
  end

  always_comb begin
    ld_o.load  = load;
    ld_o.last  = pend_last_q;
    ld_o.zero  = zero_q;
    ld_o.plane = plane_q;
  end

  // a scan only reads the store
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we_o)
    else $error("store written during a scan");

  // handing over the last voxel of a layer ends the scan
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && pend_last_q) |=> (state_q == S_IDLE))
    else $error("scan did not end after the latch item");

  // no read is issued while an unconsumed voxel would be overwritten
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && pend_q) |-> load)
    else $error("pending voxel read overwritten");

endmodule

// ===== rtl/core/led_cube_bitplane_scanner.sv =====
`timescale 1ns / 1ps

// channel | handshake                    | payload
// --------+------------------------------+------------------------------------------
// input   | in_valid_i / in_stall_o      | op_i pos_x_i pos_y_i pos_z_i colour_i plane_i
// output  | out_valid_o / out_stall_i    | red_bit_o green_bit_o blue_bit_o latch_now_o
//
// or voxel: registered store read, then the merged write
// fill writes every store entry, one entry per cycle; clear does the same, then scans layer 0 at plane 0
// scan: one store read per cycle while the output is not stalled, bounded by the read port
// after reset the store is zeroed by a sweep; in_stall_o is high meanwhile
// a stalled output holds its item; the scan pauses reads until the register frees

module led_cube_bitplane_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lcbs_pkg::op_e                  op_i,
  input  logic [lcbs_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [lcbs_pkg::COORD_W-1:0]   pos_y_i,
  input  logic [lcbs_pkg::COORD_W-1:0]   pos_z_i,
  input  logic [lcbs_pkg::COLOUR_W-1:0]  colour_i,
  input  logic [lcbs_pkg::PLANE_W-1:0]   plane_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           red_bit_o,
  output logic                           green_bit_o,
  output logic                           blue_bit_o,
  output logic                           latch_now_o
);
  import lcbs_pkg::*;

  // store port signals
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [COLOUR_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [COLOUR_W-1:0] ram_rdata;

  // handover between sequencer and output register
  ld_t  ld;
  logic can_load;

  // sequencer: reset sweep, or-merge, fill / clear sweeps and layer scan
  lcbs_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .colour_i    (colour_i),
    .plane_i     (plane_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .can_load_i  (can_load),
    .ld_o        (ld)
  );

  // voxel store, one write and one registered read per cycle
  lcbs_voxel_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // plane bit pick and output register
  lcbs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .rdata_i     (ram_rdata),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_bit_o   (red_bit_o),
    .green_bit_o (green_bit_o),
    .blue_bit_o  (blue_bit_o),
    .latch_now_o (latch_now_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lcbs_pkg::*;

  // no item moving for this many cycles means the block is hung;
  // the slowest stretch is a fill or clear sweep
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned RANDOM_ITEMS   = 250;

  // one command item as driven on the input channel
  typedef struct packed {
    op_e                 op;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [COLOUR_W-1:0] colour;
    logic [PLANE_W-1:0]  plane;
  } cube_item_t;

  // one shift clock of the layer scan
  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic latch;
  } shift_t;

  // directed row: typed means the whole layer is one known bit pattern
  typedef struct {
    op_e                 op;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [COLOUR_W-1:0] colour;
    logic [PLANE_W-1:0]  plane;
    logic                typed;
    logic [2:0]          rgb;
  } plan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  op_e                 op_i        = OP_OR;
  logic [COORD_W-1:0]  pos_x_i     = '0;
  logic [COORD_W-1:0]  pos_y_i     = '0;
  logic [COORD_W-1:0]  pos_z_i     = '0;
  logic [COLOUR_W-1:0] colour_i    = '0;
  logic [PLANE_W-1:0]  plane_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                red_bit_o;
  logic                green_bit_o;
  logic                blue_bit_o;
  logic                latch_now_o;

  // shadow copy of the voxel store, same (z, y, x) ordering as the block
  logic [COLOUR_W-1:0] shadow_store [VOXELS];
  shift_t              layer_bits [$];      // shifts caused by the last item
  shift_t              expected_shifts [$]; // shifts still owed by the block

  logic        idle_on      = 1'b1;
  int unsigned stall_run    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count    = 0;
  int unsigned shifts_seen  = 0;
  int unsigned latches_seen = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};

  led_cube_bitplane_scanner i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .colour_i    (colour_i),
    .plane_i     (plane_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_bit_o   (red_bit_o),
    .green_bit_o (green_bit_o),
    .blue_bit_o  (blue_bit_o),
    .latch_now_o (latch_now_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none or a few cycles, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
    return (z * Y_SIZE + y) * X_SIZE + x;
  endfunction

  // shift out one layer at one bit plane, y outer and x inner,
  // latch on the final shift; a layer past the cube reads as black
  function automatic void scan_layer_bits(int unsigned z, int unsigned p);
    logic [COLOUR_W-1:0] c;
    for (int unsigned y = 0; y < Y_SIZE; y++) begin
      for (int unsigned x = 0; x < X_SIZE; x++) begin
        c = (z < Z_SIZE) ? shadow_store[voxel_addr(x, y, z)] : '0;
        layer_bits.push_back('{c[2*BYTE_W+p], c[BYTE_W+p], c[p],
                               (y * X_SIZE + x == LAYER - 1)});
      end
    end
  endfunction

  // predictor: update the shadow store and collect the shifts one item causes
  function automatic void cube_model_step(cube_item_t it);
    layer_bits.delete();
    case (it.op)
      OP_OR: begin
        // coordinates past the cube are dropped
        if (it.x < X_SIZE && it.y < Y_SIZE && it.z < Z_SIZE)
          shadow_store[voxel_addr(it.x, it.y, it.z)] |= it.colour;
      end
      OP_FILL: begin
        foreach (shadow_store[i]) shadow_store[i] = it.colour;
      end
      OP_CLEAR: begin
        // clear blanks the store, then shows layer 0 so the cube goes dark
        foreach (shadow_store[i]) shadow_store[i] = '0;
        scan_layer_bits(0, 0);
      end
      default: begin
        scan_layer_bits(it.z, it.plane);
      end
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // present one item after an optional gap and hold it until accepted,
  // then run the predictor on it
  task automatic send_item(cube_item_t it);
    int unsigned gap;
    gap = idle_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= it.op;
    pos_x_i    <= it.x;
    pos_y_i    <= it.y;
    pos_z_i    <= it.z;
    colour_i   <= it.colour;
    plane_i    <= it.plane;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    cube_model_step(it);
    op_count[it.op]++;
  endtask

  // output back-pressure: bursts of stall and flow, quiet when idling is off
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= idle_len();
    end else begin
      out_stall_i <= 1'b0;
      stall_run   <= $urandom_range(0, 6);
    end
  end

  // result checker: every accepted shift against the oldest owed one
  always @(posedge clk_i) begin
    shift_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_shifts.size() == 0) begin
        flag_mismatch("shift accepted with nothing owed");
      end else begin
        want = expected_shifts.pop_front();
        if (red_bit_o !== want.red)
          flag_mismatch($sformatf("shift %0d red got %b want %b",
                                  shifts_seen, red_bit_o, want.red));
        if (green_bit_o !== want.green)
          flag_mismatch($sformatf("shift %0d green got %b want %b",
                                  shifts_seen, green_bit_o, want.green));
        if (blue_bit_o !== want.blue)
          flag_mismatch($sformatf("shift %0d blue got %b want %b",
                                  shifts_seen, blue_bit_o, want.blue));
        if (latch_now_o !== want.latch)
          flag_mismatch($sformatf("shift %0d latch got %b want %b",
                                  shifts_seen, latch_now_o, want.latch));
      end
      shifts_seen++;
      if (latch_now_o === 1'b1) latches_seen++;
    end
  end

  // watchdog: cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d shifts owed",
               quiet_cycles, expected_shifts.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // directed plan: reset contents, fill extremes per colour byte and plane,
  // clear, or-merge at the cube corners, then scans read back by the predictor
  plan_row_t plan [26] = '{
    '{OP_SCAN,  3'd0, 3'd0, 3'd0, 24'h000000, 3'd0, 1'b1, 3'b000}, // store zero after reset
    '{OP_SCAN,  3'd7, 3'd7, 3'd7, 24'hFFFFFF, 3'd7, 1'b1, 3'b000},
    '{OP_FILL,  3'd0, 3'd0, 3'd0, 24'hFFFFFF, 3'd0, 1'b0, 3'b000},
    '{OP_SCAN,  3'd0, 3'd0, 3'd7, 24'h000000, 3'd7, 1'b1, 3'b111},
    '{OP_SCAN,  3'd0, 3'd0, 3'd3, 24'h000000, 3'd0, 1'b1, 3'b111},
    '{OP_CLEAR, 3'd7, 3'd7, 3'd7, 24'hFFFFFF, 3'd7, 1'b1, 3'b000}, // clear scans layer 0
    '{OP_SCAN,  3'd0, 3'd0, 3'd7, 24'h000000, 3'd7, 1'b1, 3'b000},
    '{OP_FILL,  3'd0, 3'd0, 3'd0, 24'h800000, 3'd0, 1'b0, 3'b000},
    '{OP_SCAN,  3'd0, 3'd0, 3'd0, 24'h000000, 3'd7, 1'b1, 3'b100}, // red msb only
    '{OP_FILL,  3'd0, 3'd0, 3'd0, 24'h008000, 3'd0, 1'b0, 3'b000},
    '{OP_SCAN,  3'd0, 3'd0, 3'd5, 24'h000000, 3'd7, 1'b1, 3'b010}, // green msb only
    '{OP_FILL,  3'd0, 3'd0, 3'd0, 24'h000001, 3'd0, 1'b0, 3'b000},
    '{OP_SCAN,  3'd0, 3'd0, 3'd2, 24'h000000, 3'd0, 1'b1, 3'b001}, // blue lsb only
    '{OP_CLEAR, 3'd0, 3'd0, 3'd0, 24'h000000, 3'd0, 1'b1, 3'b000},
    '{OP_OR,    3'd0, 3'd0, 3'd0, 24'hFFFFFF, 3'd0, 1'b0, 3'b000}, // first voxel
    '{OP_OR,    3'd7, 3'd7, 3'd7, 24'hFFFFFF, 3'd7, 1'b0, 3'b000}, // last voxel
    '{OP_OR,    3'd7, 3'd0, 3'd7, 24'h010101, 3'd0, 1'b0, 3'b000},
    '{OP_OR,    3'd0, 3'd7, 3'd7, 24'h800000, 3'd0, 1'b0, 3'b000},
    '{OP_OR,    3'd7, 3'd7, 3'd7, 24'h000000, 3'd0, 1'b0, 3'b000}, // or with black
    '{OP_SCAN,  3'd0, 3'd0, 3'd7, 24'h000000, 3'd7, 1'b0, 3'b000},
    '{OP_SCAN,  3'd0, 3'd0, 3'd7, 24'h000000, 3'd0, 1'b0, 3'b000},
    '{OP_OR,    3'd3, 3'd4, 3'd0, 24'hA5A5A5, 3'd0, 1'b0, 3'b000},
    '{OP_OR,    3'd3, 3'd4, 3'd0, 24'h5A5A5A, 3'd0, 1'b0, 3'b000}, // merges to white
    '{OP_SCAN,  3'd0, 3'd0, 3'd0, 24'h000000, 3'd5, 1'b0, 3'b000},
    '{OP_FILL,  3'd0, 3'd0, 3'd0, 24'h123456, 3'd0, 1'b0, 3'b000},
    '{OP_SCAN,  3'd0, 3'd0, 3'd1, 24'h000000, 3'd4, 1'b0, 3'b000}
  };

  // stimulus
  initial begin
    cube_item_t  it;
    int unsigned pick;
    logic [COORD_W-1:0] hot_z;

    foreach (shadow_store[i]) shadow_store[i] = '0;
    hot_z = '0;

    // reset held low, then released on a clock edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    foreach (plan[r]) begin
      it = '{plan[r].op, plan[r].x, plan[r].y, plan[r].z, plan[r].colour, plan[r].plane};
      send_item(it);
      if (plan[r].typed) begin
        for (int k = 0; k < LAYER; k++)
          expected_shifts.push_back('{plan[r].rgb[2], plan[r].rgb[1], plan[r].rgb[0],
                                      (k == LAYER - 1)});
      end else begin
        foreach (layer_bits[k]) expected_shifts.push_back(layer_bits[k]);
      end
    end

    // random part: ors biased toward one hot layer so that scans of it
    // show structure, with fills and clears now and then
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // second block of fifty runs with no idling on either side
      if (n % 50 == 0) idle_on <= (n / 50 != 1);
      if (n % 30 == 0) hot_z = 3'($urandom_range(0, 7));

      // sender holds off until the block has drained everything
      if (n == 120) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_shifts.size() != 0);
      end

      pick     = $urandom_range(0, 99);
      it.op    = (pick < 50) ? OP_OR : (pick < 85) ? OP_SCAN :
                 (pick < 93) ? OP_FILL : OP_CLEAR;
      it.x     = 3'($urandom_range(0, 7));
      it.y     = 3'($urandom_range(0, 7));
      it.z     = ($urandom_range(0, 1) == 1) ? hot_z : 3'($urandom_range(0, 7));
      it.plane = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       it.colour = 24'hFFFFFF;
        1:       it.colour = 24'h000001 << $urandom_range(0, 23);
        default: it.colour = 24'($urandom());
      endcase
      send_item(it);
      foreach (layer_bits[k]) expected_shifts.push_back(layer_bits[k]);
    end

    // drain, then let any stray shift show up
    in_valid_i <= 1'b0;
    idle_on    <= 1'b0;
    while (expected_shifts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d or, %0d fill, %0d clear, %0d scan items",
             op_count[OP_OR], op_count[OP_FILL], op_count[OP_CLEAR], op_count[OP_SCAN]);
    $display("checked %0d shifts across %0d latched layers, %0d mismatches",
             shifts_seen, latches_seen, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lcbs_pkg.sv
rtl/core/lcbs_voxel_ram.sv
rtl/core/lcbs_out_stage.sv
rtl/core/lcbs_sequencer.sv
rtl/core/led_cube_bitplane_scanner.sv
tb/testbench.sv
